@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
// The modules that use them have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define CHECK_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CHECK_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/hlm_pkg.sv @@
package hlm_pkg;

   // Fixed field widths.
   localparam int TIME_W   = 48;
   localparam int NODE_W   = 8;
   localparam int MASK_BITS = 12;
   localparam int STATES_W = 2 * MASK_BITS;
   localparam int COUNT_W  = 4;
   localparam int CFG_W    = 32;
   localparam int ADDR_W   = 4;

   // Command queue depth, a power of two so the pointers wrap by themselves.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_UNREG = 2'd2;

   // Liveness classes.
   localparam logic [1:0] CLASS_SOUNDING = 2'd0;
   localparam logic [1:0] CLASS_WEAK     = 2'd1;
   localparam logic [1:0] CLASS_SILENT   = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_INTERVAL  = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_MASK      = 2'd2;

   // Reset values of the registers.
   localparam logic [CFG_W-1:0]     INTERVAL_RESET  = 32'd1000;
   localparam logic [CFG_W-1:0]     THRESHOLD_RESET = 32'd5000;
   localparam logic [MASK_BITS-1:0] MASK_RESET      = 12'd0;

   typedef struct packed {
      logic [CFG_W-1:0]     interval;
      logic [CFG_W-1:0]     threshold;
      logic [MASK_BITS-1:0] mask;
   } cfg_type;

   // One classified transaction as it waits in the queue.
   typedef struct packed {
      logic              scan;
      logic [1:0]        status;
      logic [NODE_W-1:0] node;
      logic [TIME_W-1:0] now;
   } cmd_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [STATES_W-1:0] states;
      logic [COUNT_W-1:0]  sounding;
      logic [COUNT_W-1:0]  weak_cnt;
      logic [COUNT_W-1:0]  silent;
      logic [COUNT_W-1:0]  active;
      logic [COUNT_W-1:0]  watched;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DONE
   } back_state_type;

   // A node can only be registered if it has a bit in the mask.
   function automatic logic is_registered(input logic [MASK_BITS-1:0] mask,
                                          input logic [NODE_W-1:0] idx);
      logic result;
      result = 1'b0;
      if (idx < NODE_W'(MASK_BITS)) begin
         result = mask[idx[3:0]];
      end
      return result;
   endfunction

endpackage

@@ sv/heartbeat_liveness_monitor_unit.sv @@
// Heartbeat liveness monitor for up to NODE_COUNT nodes.
// Request stream (req_): req_tuser carries the mode (0 beat, 1 scan); req_tdata carries
// the node index and the current time. A beat stamps a registered node and marks it
// sounding; a scan reclassifies every registered node from its elapsed time.
// Response stream (rsp_): one transaction per request with the status, the packed
// two-bit class of each node and, after a scan, the per-class counts.
// The APB-style csr_ port holds the beat interval, the silence threshold and the
// registration mask; write it only while no request is outstanding.
// A beat goes from the queue through the done state into the output register; a scan
// first walks the last-beat store one node per cycle through a three-stage read,
// subtract and classify pipeline. Requests are executed one at a time, each only after
// the previous result has been loaded into the output register.
// A two-entry command queue lets requests be accepted while a result waits on a
// stalled receiver; req_tready falls only when that queue is full.
// Reset clears the registers to their defaults, marks every node silent and never beat.
module heartbeat_liveness_monitor_unit #(
   parameter int NODE_COUNT = 12
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // node [7:0], now_ms [55:8]
   input  logic        req_tuser,   // mode [0]
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status [1:0], node_states [25:2],
                                    // count_sounding [29:26], count_weak [33:30],
                                    // count_silent [37:34], count_active [41:38],
                                    // count_watched [45:42], zero [47:46]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hlm_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type q_head;
   rsp_type rsp;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;

   hlm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hlm_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (req_tuser),
      .node       (req_tdata[7:0]),
      .now_ms     (req_tdata[55:8]),
      .cfg        (cfg),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   hlm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   hlm_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result fields from the lowest bit up.
   assign rsp_tdata = {2'b00, rsp.watched, rsp.active, rsp.silent, rsp.weak_cnt,
                       rsp.sounding, rsp.states, rsp.status};

endmodule

@@ sv/hlm_csr.sv @@
module hlm_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [hlm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [hlm_pkg::CFG_W-1:0]  csr_pwdata,
   output logic [hlm_pkg::CFG_W-1:0]  csr_prdata,
   output logic                       csr_pready,
   output hlm_pkg::cfg_type           cfg
);
   import hlm_pkg::*;

   logic [CFG_W-1:0]     interval_ff;
   logic [CFG_W-1:0]     threshold_ff;
   logic [MASK_BITS-1:0] mask_ff;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes in the access phase; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RESET;
         threshold_ff <= THRESHOLD_RESET;
         mask_ff      <= MASK_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_INTERVAL:  interval_ff  <= csr_pwdata;
            REG_THRESHOLD: threshold_ff <= csr_pwdata;
            REG_MASK:      mask_ff      <= csr_pwdata[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (reg_idx)
         REG_INTERVAL:  csr_prdata = interval_ff;
         REG_THRESHOLD: csr_prdata = threshold_ff;
         REG_MASK:      csr_prdata = CFG_W'(mask_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.interval  = interval_ff;
   assign cfg.threshold = threshold_ff;
   assign cfg.mask      = mask_ff;

endmodule

@@ sv/hlm_front.sv @@
module hlm_front #(
   parameter int NODE_COUNT = 12
) (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       mode,
   input  logic [hlm_pkg::NODE_W-1:0] node,
   input  logic [hlm_pkg::TIME_W-1:0] now_ms,
   input  hlm_pkg::cfg_type           cfg,
   input  logic                       q_full,
   output logic                       push,
   output hlm_pkg::cmd_type           push_cmd
);
   import hlm_pkg::*;

   // Take a transaction whenever the queue has room.
   assign req_tready = ~q_full;
   assign push       = req_tvalid & req_tready;

   // Classify: scans always pass, beats are checked for range and registration.
   // The user must change the mask only while idle; the block does not enforce it.
   always_comb begin
      push_cmd.scan = mode;
      push_cmd.node = node;
      push_cmd.now  = now_ms;
      if (mode) begin
         push_cmd.status = STATUS_OK;
      end else if (node >= NODE_W'(NODE_COUNT)) begin
         push_cmd.status = STATUS_RANGE;
      end else if (!is_registered(cfg.mask, node)) begin
         push_cmd.status = STATUS_UNREG;
      end else begin
         push_cmd.status = STATUS_OK;
      end
   end

endmodule

@@ sv/hlm_queue.sv @@
module hlm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hlm_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output hlm_pkg::cmd_type head
);
   import hlm_pkg::*;

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;

   assign full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ sv/hlm_back.sv @@
module hlm_back #(
   parameter int NODE_COUNT = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  hlm_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  hlm_pkg::cmd_type q_head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hlm_pkg::rsp_type rsp
);
   import hlm_pkg::*;
   `include "assert_macros.svh"

   localparam int IDX_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam int PACK_N = (NODE_COUNT < MASK_BITS) ? NODE_COUNT : MASK_BITS;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;
   logic                 load_rsp;
   logic                 beat_wr;
   logic [IDX_W-1:0]     beat_idx;

   // Last-beat store with one valid bit per entry; an invalid entry is treated as never beat.
   logic [TIME_W-1:0]    last_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0] beat_vld_ff;
   logic [1:0]           class_ff [NODE_COUNT];

   // Scan pipeline.
   logic [CNT_W-1:0]     issue_cnt_ff;
   logic                 issuing;
   logic [IDX_W-1:0]     issue_idx;
   logic                 scan_done;
   logic [TIME_W-1:0]    rd_last_ff;
   logic                 rd_vld_ff;
   logic                 p1_vld_ff;
   logic                 p1_act_ff;
   logic [IDX_W-1:0]     p1_idx_ff;
   logic [TIME_W:0]      p1_diff;
   logic                 p2_vld_ff;
   logic                 p2_act_ff;
   logic [IDX_W-1:0]     p2_idx_ff;
   logic [TIME_W-1:0]    p2_elapsed_ff;
   logic                 p2_back_ff;
   logic                 p2_never_ff;
   logic [1:0]           p2_class;

   logic [COUNT_W-1:0]   cnt_snd_ff;
   logic [COUNT_W-1:0]   cnt_weak_ff;
   logic [COUNT_W-1:0]   cnt_sil_ff;
   logic [STATES_W-1:0]  packed_states;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   assign issuing   = (state_ff == BK_SCAN) && (issue_cnt_ff != CNT_W'(NODE_COUNT));
   assign issue_idx = issue_cnt_ff[IDX_W-1:0];
   assign scan_done = !issuing && !p1_vld_ff && !p2_vld_ff;
   assign beat_wr   = pop && !q_head.scan && (q_head.status == STATUS_OK);
   assign beat_idx  = q_head.node[IDX_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = q_head.scan ? BK_SCAN : BK_DONE;
            end
         end
         BK_SCAN: begin
            if (scan_done) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (load_rsp) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      pop      = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         BK_IDLE: pop      = !q_empty;
         BK_DONE: load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command held for the duration of its execution.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= q_head;
      end
   end

   // Last-beat store: written by a good beat, read one entry per scan cycle.
   always_ff @(posedge clock) begin
      if (beat_wr) begin
         last_mem[beat_idx] <= q_head.now;
      end
      rd_last_ff <= last_mem[issue_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (beat_wr) begin
            beat_vld_ff[beat_idx] <= 1'b1;
         end
         rd_vld_ff <= beat_vld_ff[issue_idx];
      end
   end

   // Scan issue counter and pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff <= '0;
         p1_vld_ff    <= 1'b0;
         p1_act_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p2_act_ff    <= 1'b0;
      end else begin
         if (pop) begin
            issue_cnt_ff <= '0;
         end else if (issuing) begin
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
         end
         p1_vld_ff <= issuing;
         p1_act_ff <= issuing && is_registered(cfg.mask, NODE_W'(issue_idx));
         p2_vld_ff <= p1_vld_ff;
         p2_act_ff <= p1_act_ff;
      end
   end

   // Elapsed time stage; the borrow flags a clock that went backwards.
   assign p1_diff = {1'b0, cmd_ff.now} - {1'b0, rd_last_ff};

   always_ff @(posedge clock) begin
      p1_idx_ff     <= issue_idx;
      p2_idx_ff     <= p1_idx_ff;
      p2_elapsed_ff <= p1_diff[TIME_W-1:0];
      p2_back_ff    <= p1_diff[TIME_W];
      p2_never_ff   <= !rd_vld_ff || (rd_last_ff == '0);
   end

   // Classification stage; the interval test takes priority over the threshold.
   always_comb begin
      if (p2_never_ff) begin
         p2_class = CLASS_SILENT;
      end else if (p2_back_ff) begin
         p2_class = CLASS_SOUNDING;
      end else if (p2_elapsed_ff <= TIME_W'(cfg.interval)) begin
         p2_class = CLASS_SOUNDING;
      end else if (p2_elapsed_ff <= TIME_W'(cfg.threshold)) begin
         p2_class = CLASS_WEAK;
      end else begin
         p2_class = CLASS_SILENT;
      end
   end

   // Node classes and per-class counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            class_ff[i] <= CLASS_SILENT;
         end
         cnt_snd_ff  <= '0;
         cnt_weak_ff <= '0;
         cnt_sil_ff  <= '0;
      end else begin
         if (pop) begin
            cnt_snd_ff  <= '0;
            cnt_weak_ff <= '0;
            cnt_sil_ff  <= '0;
         end else if (p2_vld_ff && p2_act_ff) begin
            case (p2_class)
               CLASS_SOUNDING: cnt_snd_ff  <= cnt_snd_ff + 1'b1;
               CLASS_WEAK:     cnt_weak_ff <= cnt_weak_ff + 1'b1;
               default:        cnt_sil_ff  <= cnt_sil_ff + 1'b1;
            endcase
         end
         if (beat_wr) begin
            class_ff[beat_idx] <= CLASS_SOUNDING;
         end else if (p2_vld_ff && p2_act_ff) begin
            class_ff[p2_idx_ff] <= p2_class;
         end
      end
   end

   // Only the first PACK_N nodes appear in the packed states, whether masked or not.
   always_comb begin
      packed_states = '0;
      for (int i = 0; i < PACK_N; i++) begin
         packed_states[2*i +: 2] = class_ff[i];
      end
   end

   // Output register; it is reloaded once the previous result has been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.status   <= cmd_ff.status;
         rsp_ff.states   <= packed_states;
         rsp_ff.sounding <= cnt_snd_ff;
         rsp_ff.weak_cnt <= cnt_weak_ff;
         rsp_ff.silent   <= cnt_sil_ff;
         rsp_ff.active   <= cnt_snd_ff + cnt_weak_ff;
         rsp_ff.watched  <= cnt_snd_ff + cnt_weak_ff + cnt_sil_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `CHECK_CLK(a_pipe_only_in_scan, (p1_vld_ff || p2_vld_ff) |-> (state_ff == BK_SCAN), "scan pipeline busy outside a scan")
   `CHECK_CLK(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == BK_DONE), "result raised outside the done state")
   `CHECK_CLK(a_counts_bounded, (state_ff == BK_DONE) |-> ((6'(cnt_snd_ff) + 6'(cnt_weak_ff) + 6'(cnt_sil_ff)) <= 6'(MASK_BITS)), "class counts exceed the maskable nodes")

endmodule

@@ tb/heartbeat_liveness_monitor_unit_tb.sv @@
module heartbeat_liveness_monitor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hlm_pkg::*;

   localparam int NODES = MASK_BITS;
   localparam logic MODE_BEAT = 1'b0;
   localparam logic MODE_SCAN = 1'b1;
   // Index past the last register; the block must ignore writes to it.
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [STATES_W-1:0] ALL_SILENT = 24'hAAAAAA;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = NODES + 8;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 138;
   localparam int PRINT_CAP = 200;

   typedef enum logic {
      ROW_ITEM,
      ROW_CFG
   } row_kind_type;

   // One line of the directed table: either a request or a set of register writes.
   typedef struct {
      row_kind_type      kind;
      logic              scan;
      logic [NODE_W-1:0] node;
      logic [TIME_W-1:0] now;
      logic              typed;
      rsp_type           want;
      logic [CFG_W-1:0]  wr_interval;
      logic [CFG_W-1:0]  wr_threshold;
      logic [CFG_W-1:0]  wr_mask;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // node [7:0], now_ms [55:8]
   logic        req_tuser;   // mode [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // status [1:0], node_states [25:2], count_sounding [29:26],
                             // count_weak [33:30], count_silent [37:34],
                             // count_active [41:38], count_watched [45:42], zero [47:46]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the monitor's configuration and per-node state.
   logic [CFG_W-1:0]     cfg_interval;
   logic [CFG_W-1:0]     cfg_threshold;
   logic [MASK_BITS-1:0] cfg_mask;
   logic [TIME_W-1:0]    beat_stamp [NODES];
   logic [1:0]           node_class [NODES];

   rsp_type pending_replies [$];
   rsp_type seen_reply;
   rsp_type due_reply;
   row_type directed_rows [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      stall_left = 0;
   int      stall_draw = 0;
   logic    req_burst = 1'b0;
   logic    rsp_burst = 1'b0;

   heartbeat_liveness_monitor_unit #(
      .NODE_COUNT(NODES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   // Class of one node from the time since its last beat.
   function automatic logic [1:0] class_from_age(input logic [TIME_W-1:0] now,
                                                 input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] age;
      if (stamp == '0) begin
         return CLASS_SILENT;
      end
      if (now < stamp) begin
         return CLASS_SOUNDING;
      end
      age = now - stamp;
      if (age <= TIME_W'(cfg_interval)) begin
         return CLASS_SOUNDING;
      end
      if (age <= TIME_W'(cfg_threshold)) begin
         return CLASS_WEAK;
      end
      return CLASS_SILENT;
   endfunction

   // Applies one request to the shadow state and returns the reply it should produce.
   function automatic rsp_type predict_liveness(input logic scan,
                                                input logic [NODE_W-1:0] node,
                                                input logic [TIME_W-1:0] now);
      rsp_type reply;
      int      n_sounding;
      int      n_weak;
      int      n_silent;
      int      n_watched;
      reply = '0;
      n_sounding = 0;
      n_weak = 0;
      n_silent = 0;
      n_watched = 0;
      reply.status = STATUS_OK;
      if (scan == MODE_BEAT) begin
         if (node >= NODE_W'(NODES)) begin
            reply.status = STATUS_RANGE;
         end else if (!cfg_mask[node[3:0]]) begin
            reply.status = STATUS_UNREG;
         end else begin
            beat_stamp[node[3:0]] = now;
            node_class[node[3:0]] = CLASS_SOUNDING;
         end
      end else begin
         for (int i = 0; i < NODES; i++) begin
            if (cfg_mask[i]) begin
               node_class[i] = class_from_age(now, beat_stamp[i]);
               n_watched++;
               if (node_class[i] == CLASS_SOUNDING) n_sounding++;
               else if (node_class[i] == CLASS_WEAK) n_weak++;
               else n_silent++;
            end
         end
      end
      for (int i = 0; i < NODES; i++) begin
         reply.states[2*i +: 2] = node_class[i];
      end
      reply.sounding = COUNT_W'(n_sounding);
      reply.weak_cnt = COUNT_W'(n_weak);
      reply.silent   = COUNT_W'(n_silent);
      reply.active   = COUNT_W'(n_sounding + n_weak);
      reply.watched  = COUNT_W'(n_watched);
      return reply;
   endfunction

   function automatic row_type item_row(input logic scan, input logic [NODE_W-1:0] node,
                                        input logic [TIME_W-1:0] now);
      row_type row;
      row.kind = ROW_ITEM;
      row.scan = scan;
      row.node = node;
      row.now = now;
      row.typed = 1'b0;
      row.want = '0;
      row.wr_interval = '0;
      row.wr_threshold = '0;
      row.wr_mask = '0;
      return row;
   endfunction

   // A request whose reply is obvious; every count is zero for these rows.
   function automatic row_type known_row(input logic scan, input logic [NODE_W-1:0] node,
                                         input logic [TIME_W-1:0] now,
                                         input logic [1:0] status,
                                         input logic [STATES_W-1:0] states);
      row_type row;
      row = item_row(scan, node, now);
      row.typed = 1'b1;
      row.want.status = status;
      row.want.states = states;
      return row;
   endfunction

   function automatic row_type cfg_row(input logic [CFG_W-1:0] interval_word,
                                       input logic [CFG_W-1:0] threshold_word,
                                       input logic [CFG_W-1:0] mask_word);
      row_type row;
      row = item_row(MODE_BEAT, '0, '0);
      row.kind = ROW_CFG;
      row.wr_interval = interval_word;
      row.wr_threshold = threshold_word;
      row.wr_mask = mask_word;
      return row;
   endfunction

   function automatic int draw_gap(input logic burst);
      return burst ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      mismatch_count++;
      // Keep the log readable on a badly broken build.
      if (mismatch_count <= PRINT_CAP) begin
         $display("mismatch in %s at cycle %0d: got 0x%0h, expected 0x%0h",
                  what, cycle_count, got, want);
      end
   endtask

   task automatic compare_field(input string what, input logic [47:0] got,
                                input logic [47:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Writes every register once the block has drained, then the unmapped index.
   task automatic write_config(input logic [CFG_W-1:0] interval_word,
                               input logic [CFG_W-1:0] threshold_word,
                               input logic [CFG_W-1:0] mask_word);
      logic [CFG_W-1:0] words [4];
      logic [1:0]       reg_index;
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      words[REG_INTERVAL] = interval_word;
      words[REG_THRESHOLD] = threshold_word;
      words[REG_MASK] = mask_word;
      words[REG_SPARE] = $urandom;
      for (int i = 0; i < 4; i++) begin
         reg_index = 2'(i);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {reg_index, 2'b00};
         csr_pwdata <= words[reg_index];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         case (reg_index)
            REG_INTERVAL: begin
               cfg_interval = words[reg_index];
            end
            REG_THRESHOLD: begin
               cfg_threshold = words[reg_index];
            end
            REG_MASK: begin
               cfg_mask = words[reg_index][MASK_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Presents one request after an optional gap and records its expected reply.
   // The valid is left high so that a following request can go back to back.
   task automatic send_request(input logic scan, input logic [NODE_W-1:0] node,
                               input logic [TIME_W-1:0] now, input int gap,
                               input logic typed, input rsp_type want);
      rsp_type predicted;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= scan;
      req_tdata <= {now, node};
      do @(posedge clock); while (!req_tready);
      predicted = predict_liveness(scan, node, now);
      pending_replies.push_back(typed ? want : predicted);
   endtask

   // One random phase: fresh settings, then a stream of beats and scans
   // along a mostly forward-running clock.
   task automatic run_random_phase(input int n_items);
      logic [CFG_W-1:0]  interval_word;
      logic [CFG_W-1:0]  threshold_word;
      logic [CFG_W-1:0]  mask_word;
      logic [TIME_W-1:0] clock_ms;
      logic [TIME_W-1:0] now;
      logic [NODE_W-1:0] node;
      logic              scan;
      int                pick;
      case ($urandom_range(0, 9))
         0: interval_word = '0;
         1: interval_word = '1;
         default: interval_word = $urandom_range(0, 3000);
      endcase
      case ($urandom_range(0, 9))
         0: threshold_word = '0;
         1: threshold_word = '1;
         2: threshold_word = $urandom_range(0, 1000);
         default: threshold_word = interval_word + $urandom_range(0, 6000);
      endcase
      mask_word = $urandom;
      case ($urandom_range(0, 7))
         0: mask_word[MASK_BITS-1:0] = '1;
         1: mask_word[MASK_BITS-1:0] = '0;
         default: begin
         end
      endcase
      write_config(interval_word, threshold_word, mask_word);
      req_burst = ($urandom_range(0, 3) == 0);
      rsp_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
         0: clock_ms = TIME_W'($urandom_range(1, 100));
         1: clock_ms = TIME_MAX - $urandom_range(0, 20000);
         default: clock_ms = TIME_W'({$urandom, $urandom});
      endcase
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            now = '0;
         end else if (pick < 8) begin
            now = clock_ms - $urandom_range(1, 3000);
         end else if (pick < 11) begin
            now = TIME_W'({$urandom, $urandom});
         end else begin
            clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 12000)
                                                               : $urandom_range(0, 900));
            now = clock_ms;
         end
         pick = $urandom_range(0, 99);
         scan = (pick < 25) ? MODE_SCAN : MODE_BEAT;
         if (pick < 25) node = NODE_W'($urandom);
         else if (pick < 33) node = NODE_W'($urandom_range(NODES, 255));
         else if (pick < 40) node = NODE_W'($urandom);
         else node = NODE_W'($urandom_range(0, NODES - 1));
         send_request(scan, node, now, draw_gap(req_burst), 1'b0, '0);
      end
   endtask

   // Receiver: after each accepted reply, hold ready low for a random stall, none in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rsp_burst) begin
            stall_left <= 0;
            rsp_tready <= 1'b1;
         end else begin
            stall_draw = $urandom_range(0, 19);
            stall_left <= stall_draw;
            rsp_tready <= (stall_draw == 0);
         end
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Reply checker: each accepted transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_reply.status   = rsp_tdata[1:0];
         seen_reply.states   = rsp_tdata[25:2];
         seen_reply.sounding = rsp_tdata[29:26];
         seen_reply.weak_cnt = rsp_tdata[33:30];
         seen_reply.silent   = rsp_tdata[37:34];
         seen_reply.active   = rsp_tdata[41:38];
         seen_reply.watched  = rsp_tdata[45:42];
         if (pending_replies.size() == 0) begin
            report_mismatch("transaction with nothing expected", rsp_tdata, '0);
         end else begin
            due_reply = pending_replies.pop_front();
            compare_field("status", 48'(seen_reply.status), 48'(due_reply.status));
            compare_field("node_states", 48'(seen_reply.states), 48'(due_reply.states));
            compare_field("count_sounding", 48'(seen_reply.sounding),
                          48'(due_reply.sounding));
            compare_field("count_weak", 48'(seen_reply.weak_cnt), 48'(due_reply.weak_cnt));
            compare_field("count_silent", 48'(seen_reply.silent), 48'(due_reply.silent));
            compare_field("count_active", 48'(seen_reply.active), 48'(due_reply.active));
            compare_field("count_watched", 48'(seen_reply.watched),
                          48'(due_reply.watched));
            compare_field("padding", 48'(rsp_tdata[47:46]), '0);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cfg_interval = INTERVAL_RESET;
      cfg_threshold = THRESHOLD_RESET;
      cfg_mask = MASK_RESET;
      for (int i = 0; i < NODES; i++) begin
         beat_stamp[i] = '0;
         node_class[i] = CLASS_SILENT;
      end

      // Straight out of reset nothing is registered and every node reads silent.
      directed_rows.push_back(known_row(MODE_SCAN, 8'd0, '0, STATUS_OK, ALL_SILENT));
      directed_rows.push_back(known_row(MODE_BEAT, 8'd0, 48'd5, STATUS_UNREG, ALL_SILENT));
      directed_rows.push_back(known_row(MODE_BEAT, 8'd12, 48'd1, STATUS_RANGE, ALL_SILENT));
      directed_rows.push_back(known_row(MODE_BEAT, 8'd255, TIME_MAX, STATUS_RANGE,
                                        ALL_SILENT));
      // Register every node; the upper data bits must not reach the mask.
      directed_rows.push_back(cfg_row(32'd1000, 32'd5000, 32'hFFFF_FFFF));
      directed_rows.push_back(known_row(MODE_BEAT, 8'd0, TIME_MAX, STATUS_OK, 24'hAAAAA8));
      directed_rows.push_back(known_row(MODE_BEAT, 8'd11, 48'd1000, STATUS_OK, 24'h2AAAA8));
      // A beat at time zero reads sounding until the next scan finds it never beat.
      directed_rows.push_back(item_row(MODE_BEAT, 8'd1, '0));
      directed_rows.push_back(item_row(MODE_BEAT, 8'd2, 48'd100));
      directed_rows.push_back(item_row(MODE_BEAT, 8'd3, 48'd100));
      // Scans either side of the interval and threshold edges; node 0 sees the clock
      // run backwards, and the node field of a scan is ignored.
      directed_rows.push_back(item_row(MODE_SCAN, 8'hFF, 48'd1100));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, 48'd1101));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, 48'd5100));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, 48'd5101));
      // Zero interval and widest threshold.
      directed_rows.push_back(cfg_row(32'd0, 32'hFFFF_FFFF, 32'h0000_0FFF));
      directed_rows.push_back(item_row(MODE_BEAT, 8'd4, 48'd200));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, 48'd200));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, 48'd201));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, TIME_MAX));
      // Threshold below the interval, so the interval test decides; half the nodes
      // drop out of the mask and keep their last class.
      directed_rows.push_back(cfg_row(32'hFFFF_FFFF, 32'd0, 32'hFFFF_F555));
      directed_rows.push_back(item_row(MODE_BEAT, 8'd4, 48'd300));
      directed_rows.push_back(item_row(MODE_SCAN, 8'h5A, 48'd1300));
      directed_rows.push_back(item_row(MODE_SCAN, 8'd0, 48'h8000_0000_0000));
      directed_rows.push_back(item_row(MODE_BEAT, 8'd1, 48'd500));
      directed_rows.push_back(item_row(MODE_BEAT, 8'h80, 48'd7));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            write_config(directed_rows[i].wr_interval, directed_rows[i].wr_threshold,
                         directed_rows[i].wr_mask);
         end else begin
            send_request(directed_rows[i].scan, directed_rows[i].node, directed_rows[i].now,
                         draw_gap(req_burst), directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         run_random_phase(PHASE_ITEMS);
      end

      // Drain, then give the block time to show any stray transaction.
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
